// ===== rtl/card_header_parser_assert.svh =====
// ------------------------------------------------------------------------
// card header parser assertion macros
// shared property forms for the parser's concurrent checks
// ------------------------------------------------------------------------
`ifndef CARD_HEADER_PARSER_ASSERT_SVH
`define CARD_HEADER_PARSER_ASSERT_SVH

// same-cycle implication, off during reset
`define CHP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define CHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/chp_pkg.sv =====
// ------------------------------------------------------------------------
// chp_pkg
// types and constants shared by the card header parser modules
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package chp_pkg;

    localparam int unsigned COUNT_W = 4;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 4'd15;
    localparam logic [COUNT_W-1:0] HEADER_BYTES = 4'd11;

    // header byte offsets
    localparam logic [COUNT_W-1:0] OFS_MAGIC0 = 4'd0;
    localparam logic [COUNT_W-1:0] OFS_MAGIC1 = 4'd1;
    localparam logic [COUNT_W-1:0] OFS_MAGIC2 = 4'd2;
    localparam logic [COUNT_W-1:0] OFS_MAGIC3 = 4'd3;
    localparam logic [COUNT_W-1:0] OFS_KIND   = 4'd4;
    localparam logic [COUNT_W-1:0] OFS_WID_LO = 4'd5;
    localparam logic [COUNT_W-1:0] OFS_WID_HI = 4'd6;
    localparam logic [COUNT_W-1:0] OFS_HGT_LO = 4'd7;
    localparam logic [COUNT_W-1:0] OFS_HGT_HI = 4'd8;
    localparam logic [COUNT_W-1:0] OFS_BPP    = 4'd9;
    localparam logic [COUNT_W-1:0] OFS_FLAGS  = 4'd10;

    localparam logic [7:0] BPP_ONE  = 8'd1;
    localparam logic [7:0] BPP_FOUR = 8'd4;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_KIND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_KIND  = 2'd2;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_MAGIC    = 3'd2,
        ST_KIND     = 3'd3,
        ST_ZERO     = 3'd4,
        ST_BPP      = 3'd5,
        ST_MISMATCH = 3'd6
    } t_status;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [31:0]        magic;
        logic [7:0]         kind;
        logic [15:0]        width;
        logic [15:0]        height;
        logic [7:0]         bpp;
        logic [7:0]         flags;
    } t_record;

    typedef struct packed {
        logic [30:0] payload_size;
        logic [7:0]  card_flags;
        logic [7:0]  bits_per_pixel;
        logic [15:0] pixel_height;
        logic [15:0] pixel_width;
        logic [7:0]  card_kind;
        t_status     status;
    } t_result;

    localparam int unsigned RESULT_W = $bits(t_result);
    localparam int unsigned OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== rtl/card_header_parser.sv =====
// ------------------------------------------------------------------------
// card_header_parser
// image-card header decoder, one record byte per item, one verdict per record
// ------------------------------------------------------------------------
// input: s_axis_tdata[7:0] carries a record byte, s_axis_tlast marks the
// record's final byte. every byte is one item; only the final byte of a
// record produces a result item on the master side.
// output: m_axis_tdata carries status, kind, width, height, bpp, flags and
// payload size of the finished record (layout at the port).
// configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 magic word, 1 atlas kind, 2 mask kind) at the clock edge; write only
// while idle.
// throughput: one byte per cycle, sustained, while m_axis_tready is high.
// path: a result is held first in the record register, then passes through
// verdict and row-times-height multiply into the output register.
// stall: with m_axis_tready low the result holds; one further record can wait
// in the record register, and once that register is full every byte waits
// with s_axis_tready low until the output register is freed.
// reset: synchronous, active low; clears the byte count, captured fields,
// configuration registers and both valid flags.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module card_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] header_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] status, [10:3] card_kind, [26:11] pixel_width, [42:27] pixel_height,
    // [50:43] bits_per_pixel, [58:51] card_flags, [89:59] payload_size, rest zero
    output logic [chp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [chp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [31:0]      r_magic_word;
    logic [7:0]       r_atlas_kind;
    logic [7:0]       r_mask_kind;
    logic             rec_valid;
    logic             rec_take;
    chp_pkg::t_record rec;
    chp_pkg::t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_word <= '0;
            r_atlas_kind <= '0;
            r_mask_kind  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                chp_pkg::CFG_MAGIC_WORD: r_magic_word <= i_cfg_data;
                chp_pkg::CFG_ATLAS_KIND: r_atlas_kind <= i_cfg_data[7:0];
                chp_pkg::CFG_MASK_KIND:  r_mask_kind  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    chp_capture u_capture (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_take      (rec_take),
        .o_rec_valid (rec_valid),
        .o_rec       (rec)
    );

    chp_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rec_valid  (rec_valid),
        .i_rec        (rec),
        .o_take       (rec_take),
        .i_magic_word (r_magic_word),
        .i_atlas_kind (r_atlas_kind),
        .i_mask_kind  (r_mask_kind),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_result     (result)
    );

    assign m_axis_tdata = chp_pkg::OUT_TDATA_W'(result);

endmodule

// ===== rtl/chp_capture.sv =====
// ------------------------------------------------------------------------
// chp_capture
// counts record bytes, captures header fields, hands off a full record
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module chp_capture (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  logic             i_take,
    output logic             o_rec_valid,
    output chp_pkg::t_record o_rec
);

    chp_pkg::t_record r_state;
    chp_pkg::t_record n_state;
    chp_pkg::t_record r_rec;
    logic             r_rec_valid;
    logic             accept;

    assign o_ready     = !r_rec_valid || i_take;
    assign accept      = i_valid && o_ready;
    assign o_rec_valid = r_rec_valid;
    assign o_rec       = r_rec;

    // current byte merged into the captured fields
    always_comb begin
        n_state = r_state;
        unique case (r_state.count)
            chp_pkg::OFS_MAGIC0: n_state.magic[7:0]   = i_byte;
            chp_pkg::OFS_MAGIC1: n_state.magic[15:8]  = i_byte;
            chp_pkg::OFS_MAGIC2: n_state.magic[23:16] = i_byte;
            chp_pkg::OFS_MAGIC3: n_state.magic[31:24] = i_byte;
            chp_pkg::OFS_KIND:   n_state.kind         = i_byte;
            chp_pkg::OFS_WID_LO: n_state.width[7:0]   = i_byte;
            chp_pkg::OFS_WID_HI: n_state.width[15:8]  = i_byte;
            chp_pkg::OFS_HGT_LO: n_state.height[7:0]  = i_byte;
            chp_pkg::OFS_HGT_HI: n_state.height[15:8] = i_byte;
            chp_pkg::OFS_BPP:    n_state.bpp          = i_byte;
            chp_pkg::OFS_FLAGS:  n_state.flags        = i_byte;
            default: ;
        endcase
        if (r_state.count != chp_pkg::COUNT_MAX) begin
            n_state.count = r_state.count + chp_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_rec_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= i_last ? '0 : n_state;
            end
            if (accept && i_last) begin
                r_rec_valid <= 1'b1;
            end else if (i_take) begin
                r_rec_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_last) begin
            r_rec <= n_state;
        end
    end

endmodule

// ===== rtl/chp_check.sv =====
// ------------------------------------------------------------------------
// chp_check
// verdict and payload size of a captured record, held in the output register
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "card_header_parser_assert.svh"

module chp_check (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rec_valid,
    input  chp_pkg::t_record i_rec,
    output logic             o_take,
    input  logic [31:0]      i_magic_word,
    input  logic [7:0]       i_atlas_kind,
    input  logic [7:0]       i_mask_kind,
    output logic             o_valid,
    input  logic             i_ready,
    output chp_pkg::t_result o_result
);

    chp_pkg::t_result r_result;
    chp_pkg::t_result n_result;
    logic             r_valid;
    chp_pkg::t_status n_status;
    logic             kind_wants_1bpp;
    logic [15:0]      row_bytes;
    logic [31:0]      size_full;

    assign o_take   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    assign kind_wants_1bpp = (i_rec.kind == i_mask_kind) || (i_rec.kind == i_atlas_kind);

    always_comb begin
        priority if (i_rec.count < chp_pkg::HEADER_BYTES) begin
            n_status = chp_pkg::ST_SHORT;
        end else if (i_rec.magic != i_magic_word) begin
            n_status = chp_pkg::ST_MAGIC;
        end else if (i_rec.kind > i_atlas_kind) begin
            n_status = chp_pkg::ST_KIND;
        end else if (i_rec.width == 16'd0 || i_rec.height == 16'd0) begin
            n_status = chp_pkg::ST_ZERO;
        end else if (i_rec.bpp != chp_pkg::BPP_ONE && i_rec.bpp != chp_pkg::BPP_FOUR) begin
            n_status = chp_pkg::ST_BPP;
        end else if (kind_wants_1bpp != (i_rec.bpp == chp_pkg::BPP_ONE)) begin
            n_status = chp_pkg::ST_MISMATCH;
        end else begin
            n_status = chp_pkg::ST_OK;
        end
    end

    // rows padded to whole bytes: half-bytes at 4 bpp, bits at 1 bpp
    always_comb begin
        if (i_rec.bpp == chp_pkg::BPP_FOUR) begin
            row_bytes = 16'((17'(i_rec.width) + 17'd1) >> 1);
        end else begin
            row_bytes = 16'((17'(i_rec.width) + 17'd7) >> 3);
        end
        size_full = {16'd0, row_bytes} * {16'd0, i_rec.height};
    end

    always_comb begin
        n_result.status         = n_status;
        n_result.card_kind      = i_rec.kind;
        n_result.pixel_width    = i_rec.width;
        n_result.pixel_height   = i_rec.height;
        n_result.bits_per_pixel = i_rec.bpp;
        n_result.card_flags     = i_rec.flags;
        n_result.payload_size   = (n_status == chp_pkg::ST_OK) ? size_full[30:0] : 31'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_rec_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_rec_valid) begin
            r_result <= n_result;
        end
    end

    `CHP_ASSERT_SAME(a_fail_no_size, i_clk, i_rst_n,
        r_valid && r_result.status != chp_pkg::ST_OK, r_result.payload_size == 31'd0,
        "failed verdict carries a payload size")
    `CHP_ASSERT_SAME(a_ok_fields, i_clk, i_rst_n,
        r_valid && r_result.status == chp_pkg::ST_OK,
        (r_result.bits_per_pixel == chp_pkg::BPP_ONE ||
         r_result.bits_per_pixel == chp_pkg::BPP_FOUR) &&
        r_result.pixel_width != 16'd0 && r_result.pixel_height != 16'd0,
        "ok verdict with bad bpp or zero size")
    `CHP_ASSERT_NEXT(a_record_loaded, i_clk, i_rst_n,
        i_rec_valid && o_take, r_valid && r_result.card_kind == $past(i_rec.kind),
        "record not loaded into output register")

endmodule
